[sv/fqs_pkg.sv]
// shared types, constants, microprogram and helpers for the ready / i/o wait queue scheduler
package fqs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int UPC_W = 5;

	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [UPC_W-1:0]   upc_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_YIELD = 2'd1,
		OP_TERM  = 2'd2,
		OP_BLOCK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		U_NOP,
		U_SET_FULL,
		U_SET_EMPTY,
		U_SET_OK,
		U_SCAN_INIT,
		U_IDX_INC,
		U_R_PUSH_ID,
		U_R_PUSH_WOKEN,
		U_RD_WAIT_HEAD,
		U_RD_READY_HEAD,
		U_RD_READY_IDX,
		U_R_POP,
		U_R_SHIFT,
		U_R_DROP_TAIL,
		U_W_PUSH_ID,
		U_EMIT
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_RFULL,
		C_WFULL,
		C_REMPTY,
		C_NOWAKE,
		C_IDX_END,
		C_NOMATCH,
		C_OUTBUSY
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} ucw_t;

	typedef struct packed {
		logic rfull;
		logic wfull;
		logic rempty;
		logic nowake;
		logic idx_end;
		logic nomatch;
		logic out_busy;
	} flags_t;

	// program labels
	localparam upc_t L_ADD     = 5'd0;
	localparam upc_t L_ADD_1   = 5'd1;
	localparam upc_t L_ADD_2   = 5'd2;
	localparam upc_t L_ADD_3   = 5'd3;
	localparam upc_t L_YLD     = 5'd4;
	localparam upc_t L_YLD_1   = 5'd5;
	localparam upc_t L_BLK     = 5'd6;
	localparam upc_t L_BLK_1   = 5'd7;
	localparam upc_t L_TRM     = 5'd8;
	localparam upc_t L_TRM_RD  = 5'd9;
	localparam upc_t L_TRM_CMP = 5'd10;
	localparam upc_t L_TRM_HIT = 5'd11;
	localparam upc_t L_SHF_RD  = 5'd12;
	localparam upc_t L_SHF_WR  = 5'd13;
	localparam upc_t L_SHF_END = 5'd14;
	localparam upc_t L_FULL    = 5'd15;
	localparam upc_t L_EMPTY   = 5'd16;
	localparam upc_t L_EMIT    = 5'd17;

	function automatic upc_t entry_of(op_t op);
		upc_t e;
		case (op)
			OP_ADD:   e = L_ADD;
			OP_YIELD: e = L_YLD;
			OP_TERM:  e = L_TRM;
			OP_BLOCK: e = L_BLK;
			default:  e = L_EMIT;
		endcase
		return e;
	endfunction

	// control store
	function automatic ucw_t ucode(upc_t pc);
		ucw_t w;
		case (pc)
			L_ADD:     w = '{U_NOP,           C_RFULL,   L_FULL};
			L_ADD_1:   w = '{U_R_PUSH_ID,     C_NEVER,   L_EMIT};
			L_ADD_2:   w = '{U_RD_WAIT_HEAD,  C_NOWAKE,  L_EMIT};
			L_ADD_3:   w = '{U_R_PUSH_WOKEN,  C_ALWAYS,  L_EMIT};
			L_YLD:     w = '{U_RD_READY_HEAD, C_REMPTY,  L_EMPTY};
			L_YLD_1:   w = '{U_R_POP,         C_ALWAYS,  L_EMIT};
			L_BLK:     w = '{U_NOP,           C_WFULL,   L_FULL};
			L_BLK_1:   w = '{U_W_PUSH_ID,     C_ALWAYS,  L_YLD};
			L_TRM:     w = '{U_SCAN_INIT,     C_NEVER,   L_EMIT};
			L_TRM_RD:  w = '{U_RD_READY_IDX,  C_IDX_END, L_EMIT};
			L_TRM_CMP: w = '{U_IDX_INC,       C_NOMATCH, L_TRM_RD};
			L_TRM_HIT: w = '{U_SET_OK,        C_NEVER,   L_EMIT};
			L_SHF_RD:  w = '{U_RD_READY_IDX,  C_IDX_END, L_SHF_END};
			L_SHF_WR:  w = '{U_R_SHIFT,       C_ALWAYS,  L_SHF_RD};
			L_SHF_END: w = '{U_R_DROP_TAIL,   C_ALWAYS,  L_EMIT};
			L_FULL:    w = '{U_SET_FULL,      C_ALWAYS,  L_EMIT};
			L_EMPTY:   w = '{U_SET_EMPTY,     C_ALWAYS,  L_EMIT};
			L_EMIT:    w = '{U_EMIT,          C_OUTBUSY, L_EMIT};
			default:   w = '{U_EMIT,          C_OUTBUSY, L_EMIT};
		endcase
		return w;
	endfunction

	// circular buffer address: head plus offset, offset at most the depth
	function automatic ptr_t qaddr(ptr_t head, cnt_t off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(head) + SUM_W'(off);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic id_t id_in(logic [7:0] x);
		logic [15:0] t;
		t = 16'(x);
		return t[ID_BITS-1:0];
	endfunction

	function automatic logic [7:0] id_out(id_t v);
		logic [15:0] t;
		t = 16'(v);
		return t[7:0];
	endfunction

endpackage

[sv/fqs_ram.sv]
// generic single write, single read ram with registered read data
module fqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/fqs_seq.sv]
// microcode sequencer: step counter, control store lookup and conditional jumps
module fqs_seq import fqs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  upc_t   entry,
	input  flags_t flags,
	output logic   busy,
	output uop_t   uop
);

	upc_t upc_q;
	logic busy_q;
	ucw_t cw;
	logic take;
	logic done;

	assign cw = ucode(upc_q);

	always_comb begin
		case (cw.cond)
			C_NEVER:   take = 1'b0;
			C_ALWAYS:  take = 1'b1;
			C_RFULL:   take = flags.rfull;
			C_WFULL:   take = flags.wfull;
			C_REMPTY:  take = flags.rempty;
			C_NOWAKE:  take = flags.nowake;
			C_IDX_END: take = flags.idx_end;
			C_NOMATCH: take = flags.nomatch;
			C_OUTBUSY: take = flags.out_busy;
			default:   take = 1'b0;
		endcase
	end

	// final step completes only once the output register is free
	assign done = busy_q && (cw.uop == U_EMIT) && !flags.out_busy;
	assign uop  = busy_q ? cw.uop : U_NOP;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= L_EMIT;
			busy_q <= 1'b0;
		end else if (start) begin
			upc_q  <= entry;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			upc_q <= take ? cw.target : upc_q + UPC_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[sv/fifo_ready_and_io_wait_queues.sv]
// top level of the ready queue / i/o wait queue thread scheduler
// usage:
//   request channel: in_valid / in_stall with opcode, thread_id, disk_ready.
//   one request is worked on at a time; in_stall stays high from the transfer
//   of a request until its result has been loaded into the output register.
//   result channel: out_valid / out_stall with dispatched, dispatch_id, woken,
//   woken_id, status; exactly one result per request, in request order.
//   a microcode sequencer steps a small datapath one control word per cycle,
//   holding its final step while out_stall holds a result; both queues are
//   circular buffers in single-port-read rams, so every queue entry touched
//   costs a read step. terminate scans the ready queue for the id and, on a
//   hit, closes the gap by shifting the later entries toward the head.
//   reset clears both queue counts and pointers; ram contents stay unknown and
//   are only used below the counts.
//   while out_stall holds a result, the sequencer waits in its final step and
//   the finished request keeps in_stall high; nothing is lost.
module fifo_ready_and_io_wait_queues import fqs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] thread_id,
	input  logic       disk_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       dispatched,
	output logic [7:0] dispatch_id,
	output logic       woken,
	output logic [7:0] woken_id,
	output logic [1:0] status
);

	logic   busy;
	logic   start;
	uop_t   uop;
	flags_t flags;

	// queue pointers and counts
	ptr_t rhead_q;
	cnt_t rcount_q;
	ptr_t whead_q;
	cnt_t wcount_q;
	cnt_t idx_q;

	// latched request
	id_t  req_id_q;
	logic req_disk_q;

	// working result
	logic    res_disp_q;
	id_t     res_disp_id_q;
	logic    res_wok_q;
	id_t     res_wok_id_q;
	status_t res_status_q;

	// output register
	logic    out_valid_q;
	logic    out_disp_q;
	id_t     out_disp_id_q;
	logic    out_wok_q;
	id_t     out_wok_id_q;
	status_t out_status_q;

	// ram ports
	logic r_we;
	ptr_t r_waddr;
	id_t  r_wdata;
	ptr_t r_raddr;
	id_t  r_rdata;
	logic w_we;
	ptr_t w_waddr;
	ptr_t w_raddr;
	id_t  w_rdata;

	assign in_stall = busy;
	assign start    = in_valid && !busy;

	assign flags.rfull    = (rcount_q == CNT_W'(QUEUE_DEPTH));
	assign flags.wfull    = (wcount_q == CNT_W'(QUEUE_DEPTH));
	assign flags.rempty   = (rcount_q == '0);
	assign flags.nowake   = (wcount_q == '0) || !req_disk_q ||
		(rcount_q == CNT_W'(QUEUE_DEPTH));
	assign flags.idx_end  = (idx_q == rcount_q);
	assign flags.nomatch  = (r_rdata != req_id_q);
	assign flags.out_busy = out_valid_q && out_stall;

	fqs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.entry  (entry_of(op_t'(opcode))),
		.flags  (flags),
		.busy   (busy),
		.uop    (uop)
	);

	// ram address and write selection from the current micro-op
	always_comb begin
		r_we    = 1'b0;
		r_waddr = qaddr(rhead_q, rcount_q);
		r_wdata = req_id_q;
		r_raddr = rhead_q;
		w_we    = 1'b0;
		w_waddr = qaddr(whead_q, wcount_q);
		w_raddr = whead_q;
		case (uop)
			U_R_PUSH_ID: begin
				r_we = 1'b1;
			end
			U_R_PUSH_WOKEN: begin
				r_we    = 1'b1;
				r_wdata = w_rdata;
			end
			U_R_SHIFT: begin
				// move entry idx one place toward the head
				r_we    = 1'b1;
				r_waddr = qaddr(rhead_q, idx_q - CNT_W'(1));
				r_wdata = r_rdata;
			end
			U_RD_READY_IDX: begin
				r_raddr = qaddr(rhead_q, idx_q);
			end
			U_W_PUSH_ID: begin
				w_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	fqs_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	fqs_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_wait_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (req_id_q),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhead_q  <= '0;
			rcount_q <= '0;
			whead_q  <= '0;
			wcount_q <= '0;
			idx_q    <= '0;
		end else begin
			case (uop)
				U_SCAN_INIT: idx_q <= '0;
				U_IDX_INC:   idx_q <= idx_q + CNT_W'(1);
				U_R_SHIFT:   idx_q <= idx_q + CNT_W'(1);
				U_R_PUSH_ID: rcount_q <= rcount_q + CNT_W'(1);
				U_R_PUSH_WOKEN: begin
					// wait head moves to the ready tail
					rcount_q <= rcount_q + CNT_W'(1);
					whead_q  <= qaddr(whead_q, CNT_W'(1));
					wcount_q <= wcount_q - CNT_W'(1);
				end
				U_R_POP: begin
					rhead_q  <= qaddr(rhead_q, CNT_W'(1));
					rcount_q <= rcount_q - CNT_W'(1);
				end
				U_R_DROP_TAIL: rcount_q <= rcount_q - CNT_W'(1);
				U_W_PUSH_ID:   wcount_q <= wcount_q + CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	// request latch and working result
	always_ff @(posedge clk) begin
		if (start) begin
			req_id_q      <= id_in(thread_id);
			req_disk_q    <= disk_ready;
			res_disp_q    <= 1'b0;
			res_disp_id_q <= '0;
			res_wok_q     <= 1'b0;
			res_wok_id_q  <= '0;
			res_status_q  <= ST_OK;
		end else begin
			case (uop)
				U_SET_FULL:  res_status_q <= ST_FULL;
				U_SET_EMPTY: res_status_q <= ST_EMPTY;
				U_SET_OK:    res_status_q <= ST_OK;
				U_SCAN_INIT: res_status_q <= ST_NOTFOUND;
				U_R_PUSH_WOKEN: begin
					res_wok_q    <= 1'b1;
					res_wok_id_q <= w_rdata;
				end
				U_R_POP: begin
					res_disp_q    <= 1'b1;
					res_disp_id_q <= r_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	// output register: loads when the final step runs, clears on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uop == U_EMIT && !flags.out_busy) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uop == U_EMIT && !flags.out_busy) begin
			out_disp_q    <= res_disp_q;
			out_disp_id_q <= res_disp_id_q;
			out_wok_q     <= res_wok_q;
			out_wok_id_q  <= res_wok_id_q;
			out_status_q  <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign dispatched  = out_disp_q;
	assign dispatch_id = id_out(out_disp_id_q);
	assign woken       = out_wok_q;
	assign woken_id    = id_out(out_wok_id_q);
	assign status      = out_status_q;

	// queue counts never pass the depth
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(rcount_q <= CNT_W'(QUEUE_DEPTH)) && (wcount_q <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	// a new result only appears from the final micro-step
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(uop == U_EMIT))
		else $error("result without final step");

	// a taken request stalls the input side once it has been transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request not held busy");

	// a dispatch or wake-up always reports success
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (dispatched || woken)) |-> (status == ST_OK))
		else $error("dispatch or wake-up with error status");

endmodule
